### design/dpd_pkg.sv
// ----------------------------------------------------------------------------
// dpd_pkg: shared types and constants of the dfa pair distinguisher
// Controller states, command and status bundles, fixed field widths.
// ----------------------------------------------------------------------------
package dpd_pkg;

    localparam int IN_W        = 3;
    localparam int ROW_W       = 2 * IN_W + 1;
    localparam int WIT_BITS    = 28;
    localparam int LEN_W       = 5;
    localparam int MAX_RESULTS = 28;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH_I,
        ST_FETCH_J,
        ST_LOAD_J,
        ST_INIT_PAIR,
        ST_TRY_A,
        ST_MARK_A,
        ST_TRY_B,
        ST_MARK_B,
        ST_OUT_READ,
        ST_OUT_LOAD,
        ST_OUT_WAIT
    } t_state;

    typedef struct packed {
        logic load_row;
        logic start;
        logic sel_j;
        logic cap_i;
        logic cap_j;
        logic init_pair;
        logic rd_q;
        logic rd_b;
        logic mark_a;
        logic mark_b;
        logic next_pair;
        logic new_sweep;
        logic out_load;
    } t_ctrl;

    typedef struct packed {
        logic last_pair;
        logic hit_a;
        logic hit_b;
        logic changed;
        logic out_last;
        logic out_taken;
    } t_stat;

endpackage

### design/dpd_ram.sv
// ----------------------------------------------------------------------------
// dpd_ram: generic simple dual-port ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dpd_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/dpd_controller.sv
// ----------------------------------------------------------------------------
// dpd_controller: sequencing of row loads, marking passes and result beats
// Walks every pair through table fetch, acceptance or successor checks.
// ----------------------------------------------------------------------------
module dpd_controller (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_last_row,
    input  dpd_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output dpd_pkg::t_ctrl o_ctrl
);

    import dpd_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_init_phase;
    logic   n_init_phase;
    logic   sweep_again;

    // a marking state changes the pass even before the flag register updates
    assign sweep_again = i_stat.changed || (r_state == ST_MARK_A) || (r_state == ST_MARK_B);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_init_phase <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_init_phase <= n_init_phase;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_init_phase = r_init_phase;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_last_row) begin
                    n_state      = ST_FETCH_I;
                    n_init_phase = 1'b1;
                end
            end
            ST_FETCH_I: n_state = ST_FETCH_J;
            ST_FETCH_J: n_state = ST_LOAD_J;
            ST_LOAD_J: begin
                n_state = r_init_phase ? ST_INIT_PAIR : ST_TRY_A;
            end
            ST_INIT_PAIR: begin
                n_state = ST_FETCH_I;
                if (i_stat.last_pair) begin
                    n_init_phase = 1'b0;
                end
            end
            ST_TRY_A: begin
                n_state = i_stat.hit_a ? ST_MARK_A : ST_TRY_B;
            end
            ST_TRY_B, ST_MARK_A, ST_MARK_B: begin
                if ((r_state == ST_TRY_B) && i_stat.hit_b) begin
                    n_state = ST_MARK_B;
                end else if (!i_stat.last_pair || sweep_again) begin
                    n_state = ST_FETCH_I;
                end else begin
                    n_state = ST_OUT_READ;
                end
            end
            ST_OUT_READ: n_state = ST_OUT_LOAD;
            ST_OUT_LOAD: n_state = ST_OUT_WAIT;
            ST_OUT_WAIT: begin
                if (i_stat.out_taken) begin
                    n_state = i_stat.out_last ? ST_IDLE : ST_OUT_READ;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl     = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_ctrl.load_row = i_in_valid;
                o_ctrl.start    = i_in_valid && i_last_row;
            end
            ST_FETCH_I: begin
                o_ctrl.sel_j = 1'b0;
            end
            ST_FETCH_J: begin
                o_ctrl.sel_j = 1'b1;
                o_ctrl.cap_i = 1'b1;
            end
            ST_LOAD_J: begin
                o_ctrl.sel_j = 1'b1;
                o_ctrl.cap_j = 1'b1;
            end
            ST_INIT_PAIR: begin
                o_ctrl.init_pair = 1'b1;
                o_ctrl.next_pair = !i_stat.last_pair;
                o_ctrl.new_sweep = i_stat.last_pair;
            end
            ST_TRY_A: begin
                o_ctrl.rd_q = i_stat.hit_a;
            end
            ST_TRY_B, ST_MARK_A, ST_MARK_B: begin
                o_ctrl.mark_a = (r_state == ST_MARK_A);
                o_ctrl.mark_b = (r_state == ST_MARK_B);
                if ((r_state == ST_TRY_B) && i_stat.hit_b) begin
                    o_ctrl.rd_q = 1'b1;
                    o_ctrl.rd_b = 1'b1;
                end else begin
                    o_ctrl.next_pair = !i_stat.last_pair;
                    o_ctrl.new_sweep = i_stat.last_pair;
                end
            end
            ST_OUT_READ: begin
                o_ctrl.rd_q = 1'b0;
            end
            ST_OUT_LOAD: begin
                o_ctrl.out_load = 1'b1;
            end
            ST_OUT_WAIT: begin
                o_ctrl.next_pair = i_stat.out_taken && !i_stat.out_last;
            end
            default: begin
                o_ctrl = '0;
            end
        endcase
    end

endmodule

### design/dpd_datapath.sv
// ----------------------------------------------------------------------------
// dpd_datapath: transition table, pair marks, witness store and result register
// Pair counters, successor pair lookup and witness extension.
// ----------------------------------------------------------------------------
module dpd_datapath #(
    parameter int NUM_STATES = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dpd_pkg::t_ctrl                i_ctrl,
    output dpd_pkg::t_stat                o_stat,
    input  logic [dpd_pkg::IN_W-1:0]      i_row_state,
    input  logic [dpd_pkg::IN_W-1:0]      i_next_on_a,
    input  logic [dpd_pkg::IN_W-1:0]      i_next_on_b,
    input  logic                          i_is_accepting,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [dpd_pkg::IN_W-1:0]      o_first_state,
    output logic [dpd_pkg::IN_W-1:0]      o_second_state,
    output logic                          o_distinguished,
    output logic [dpd_pkg::WIT_BITS-1:0]  o_witness_symbols,
    output logic [dpd_pkg::LEN_W-1:0]     o_witness_length,
    output logic                          o_last_pair
);

    import dpd_pkg::*;

    localparam int NUM_PAIRS = NUM_STATES * (NUM_STATES - 1) / 2;
    localparam int TOTAL     = (NUM_PAIRS < MAX_RESULTS) ? NUM_PAIRS : MAX_RESULTS;
    localparam int SW        = ($clog2(NUM_STATES + 1) > IN_W) ? $clog2(NUM_STATES + 1) : IN_W;
    localparam int AW        = $clog2(NUM_STATES);
    localparam int PW        = $clog2(NUM_PAIRS + 1);
    localparam int WW        = LEN_W + WIT_BITS;

    localparam logic [SW-1:0]    N_S       = SW'(NUM_STATES);
    localparam logic [PW-1:0]    P_LAST    = PW'(NUM_PAIRS - 1);
    localparam logic [PW-1:0]    P_OUTLAST = PW'(TOTAL - 1);
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(WIT_BITS);

    function automatic logic [PW-1:0] pair_idx(input logic [SW-1:0] lo, input logic [SW-1:0] hi);
        int l;
        int h;
        l = int'(lo);
        h = int'(hi);
        return PW'(l * (2 * NUM_STATES - l - 1) / 2 + h - l - 1);
    endfunction

    // pair walk
    logic [SW-1:0] r_i;
    logic [SW-1:0] r_j;
    logic [PW-1:0] r_p;

    // transition table
    logic                  tbl_we;
    logic [AW-1:0]         tbl_waddr;
    logic [AW-1:0]         tbl_raddr;
    logic [ROW_W-1:0]      tbl_rdata;
    logic [ROW_W-1:0]      tbl_row;
    logic [NUM_STATES-1:0] r_tbl_vld;
    logic                  r_tbl_q_vld;
    logic [ROW_W-1:0]      r_row_i;
    logic [ROW_W-1:0]      r_row_j;

    // marks and witnesses
    logic [NUM_PAIRS-1:0]  r_marked;
    logic                  r_changed;
    logic                  wit_we;
    logic [PW-1:0]         wit_raddr;
    logic [WW-1:0]         wit_wdata;
    logic [WW-1:0]         wit_rdata;
    logic [WIT_BITS-1:0]   wit_q;
    logic [LEN_W-1:0]      len_q;
    logic [LEN_W-1:0]      len_new;

    // successor pairs
    logic [SW-1:0] ai, aj, bi, bj;
    logic [SW-1:0] lo_a, hi_a, lo_b, hi_b;
    logic          ok_a, ok_b;
    logic [PW-1:0] q_a, q_b;

    // result register
    logic                r_out_valid;
    logic [IN_W-1:0]     r_first;
    logic [IN_W-1:0]     r_second;
    logic                r_dist;
    logic [WIT_BITS-1:0] r_wit;
    logic [LEN_W-1:0]    r_len;
    logic                r_last;

    assign tbl_we    = i_ctrl.load_row && (SW'(i_row_state) < N_S);
    assign tbl_waddr = AW'(i_row_state);
    assign tbl_raddr = i_ctrl.sel_j ? r_j[AW-1:0] : r_i[AW-1:0];
    assign tbl_row   = r_tbl_q_vld ? tbl_rdata : '0;

    dpd_ram #(
        .WIDTH  (ROW_W),
        .DEPTH  (NUM_STATES),
        .ADDR_W (AW)
    ) u_tbl_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata ({i_is_accepting, i_next_on_b, i_next_on_a}),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tbl_vld <= '0;
        end else if (tbl_we) begin
            r_tbl_vld[tbl_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tbl_q_vld <= r_tbl_vld[tbl_raddr];
        if (i_ctrl.cap_i) begin
            r_row_i <= tbl_row;
        end
        if (i_ctrl.cap_j) begin
            r_row_j <= tbl_row;
        end
    end

    // successor pair on each symbol
    assign ai   = SW'(r_row_i[IN_W-1:0]);
    assign aj   = SW'(r_row_j[IN_W-1:0]);
    assign bi   = SW'(r_row_i[2*IN_W-1:IN_W]);
    assign bj   = SW'(r_row_j[2*IN_W-1:IN_W]);
    assign ok_a = (ai < N_S) && (aj < N_S) && (ai != aj);
    assign ok_b = (bi < N_S) && (bj < N_S) && (bi != bj);
    assign lo_a = (ai < aj) ? ai : aj;
    assign hi_a = (ai < aj) ? aj : ai;
    assign lo_b = (bi < bj) ? bi : bj;
    assign hi_b = (bi < bj) ? bj : bi;
    assign q_a  = pair_idx(lo_a, hi_a);
    assign q_b  = pair_idx(lo_b, hi_b);

    // witness extension
    assign wit_q     = wit_rdata[WIT_BITS-1:0];
    assign len_q     = wit_rdata[WW-1:WIT_BITS];
    assign len_new   = (len_q >= LEN_MAX) ? LEN_MAX : len_q + LEN_W'(1);
    assign wit_we    = i_ctrl.init_pair || i_ctrl.mark_a || i_ctrl.mark_b;
    assign wit_wdata = i_ctrl.init_pair ? '0 :
                       {len_new, wit_q[WIT_BITS-2:0], i_ctrl.mark_b};
    assign wit_raddr = i_ctrl.rd_q ? (i_ctrl.rd_b ? q_b : q_a) : r_p;

    dpd_ram #(
        .WIDTH  (WW),
        .DEPTH  (NUM_PAIRS),
        .ADDR_W (PW)
    ) u_wit_ram (
        .i_clk   (i_clk),
        .i_we    (wit_we),
        .i_waddr (r_p),
        .i_wdata (wit_wdata),
        .i_raddr (wit_raddr),
        .o_rdata (wit_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marked  <= '0;
            r_changed <= 1'b0;
        end else begin
            if (i_ctrl.start) begin
                r_marked <= '0;
            end else if (i_ctrl.init_pair) begin
                r_marked[r_p] <= r_row_i[ROW_W-1] ^ r_row_j[ROW_W-1];
            end else if (i_ctrl.mark_a || i_ctrl.mark_b) begin
                r_marked[r_p] <= 1'b1;
            end
            if (i_ctrl.start || i_ctrl.new_sweep) begin
                r_changed <= 1'b0;
            end else if (i_ctrl.mark_a || i_ctrl.mark_b) begin
                r_changed <= 1'b1;
            end
        end
    end

    // row-major pair counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= '0;
            r_j <= SW'(1);
            r_p <= '0;
        end else if (i_ctrl.start || i_ctrl.new_sweep) begin
            r_i <= '0;
            r_j <= SW'(1);
            r_p <= '0;
        end else if (i_ctrl.next_pair) begin
            r_p <= r_p + PW'(1);
            if (r_j == N_S - SW'(1)) begin
                r_i <= r_i + SW'(1);
                r_j <= r_i + SW'(2);
            end else begin
                r_j <= r_j + SW'(1);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.out_load) begin
            r_first  <= r_i[IN_W-1:0];
            r_second <= r_j[IN_W-1:0];
            r_dist   <= r_marked[r_p];
            r_wit    <= r_marked[r_p] ? wit_q : '0;
            r_len    <= r_marked[r_p] ? len_q : '0;
            r_last   <= (r_p == P_OUTLAST);
        end
    end

    assign o_stat.last_pair = (r_p == P_LAST);
    assign o_stat.hit_a     = !r_marked[r_p] && ok_a && r_marked[q_a];
    assign o_stat.hit_b     = !r_marked[r_p] && ok_b && r_marked[q_b];
    assign o_stat.changed   = r_changed;
    assign o_stat.out_last  = (r_p == P_OUTLAST);
    assign o_stat.out_taken = r_out_valid && i_out_ready;

    assign o_out_valid       = r_out_valid;
    assign o_first_state     = r_first;
    assign o_second_state    = r_second;
    assign o_distinguished   = r_dist;
    assign o_witness_symbols = r_wit;
    assign o_witness_length  = r_len;
    assign o_last_pair       = r_last;

endmodule

### design/dfa_pair_distinguisher.sv
// ----------------------------------------------------------------------------
// dfa_pair_distinguisher: state pair equivalence by table filling
// Loads a two-symbol transition table and reports each pair (up to 28) with a witness.
// ----------------------------------------------------------------------------
// Each input beat writes one table row (rows naming a state beyond NUM_STATES-1
// are dropped). A beat with last_row set starts a run: an acceptance pass over
// all pairs (fetch both rows, set the initial mark), then marking sweeps over all
// pairs, repeated until a sweep marks nothing, then one result beat per pair (at
// most 28), each held until taken before the next is loaded. The pace is set by
// the single read port of the table ram (two row fetches per pair) and of the
// witness ram (one successor witness read before each mark). No input beat is
// taken while a run is in progress. The table keeps its rows across runs and
// reads as zero until written after reset.
// ----------------------------------------------------------------------------
module dfa_pair_distinguisher #(
    parameter int NUM_STATES = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [dpd_pkg::IN_W-1:0]      i_row_state,
    input  logic [dpd_pkg::IN_W-1:0]      i_next_on_a,
    input  logic [dpd_pkg::IN_W-1:0]      i_next_on_b,
    input  logic                          i_is_accepting,
    input  logic                          i_last_row,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [dpd_pkg::IN_W-1:0]      o_first_state,
    output logic [dpd_pkg::IN_W-1:0]      o_second_state,
    output logic                          o_distinguished,
    output logic [dpd_pkg::WIT_BITS-1:0]  o_witness_symbols,
    output logic [dpd_pkg::LEN_W-1:0]     o_witness_length,
    output logic                          o_last_pair
);

    import dpd_pkg::*;

    t_ctrl ctrl;
    t_stat stat;

    dpd_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_last_row (i_last_row),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_ctrl     (ctrl)
    );

    dpd_datapath #(
        .NUM_STATES (NUM_STATES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctrl            (ctrl),
        .o_stat            (stat),
        .i_row_state       (i_row_state),
        .i_next_on_a       (i_next_on_a),
        .i_next_on_b       (i_next_on_b),
        .i_is_accepting    (i_is_accepting),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_first_state     (o_first_state),
        .o_second_state    (o_second_state),
        .o_distinguished   (o_distinguished),
        .o_witness_symbols (o_witness_symbols),
        .o_witness_length  (o_witness_length),
        .o_last_pair       (o_last_pair)
    );

endmodule

### design/dpd_checker.sv
// ----------------------------------------------------------------------------
// dpd_checker: port-level checks of the dfa pair distinguisher
// Result beat stability, run framing and empty witnesses.
// ----------------------------------------------------------------------------
module dpd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic [dpd_pkg::IN_W-1:0]      i_row_state,
    input logic [dpd_pkg::IN_W-1:0]      i_next_on_a,
    input logic [dpd_pkg::IN_W-1:0]      i_next_on_b,
    input logic                          i_is_accepting,
    input logic                          i_last_row,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [dpd_pkg::IN_W-1:0]      o_first_state,
    input logic [dpd_pkg::IN_W-1:0]      o_second_state,
    input logic                          o_distinguished,
    input logic [dpd_pkg::WIT_BITS-1:0]  o_witness_symbols,
    input logic [dpd_pkg::LEN_W-1:0]     o_witness_length,
    input logic                          o_last_pair
);

    import dpd_pkg::*;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid
            && $stable(o_first_state) && $stable(o_second_state)
            && $stable(o_distinguished) && $stable(o_witness_symbols)
            && $stable(o_witness_length) && $stable(o_last_pair))
        else $error("result beat changed while stalled");

    // no row beat taken while results are pending
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready during result phase");

    // a run start closes the input side
    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_last_row |=> !o_in_ready)
        else $error("input still ready after run start");

    // final result beat returns the block to loading
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_last_pair |=> !o_out_valid && o_in_ready)
        else $error("block not idle after final result beat");

    // undistinguished pairs carry an empty witness
    a_empty_wit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_distinguished |-> (o_witness_length == '0)
            && (o_witness_symbols == '0))
        else $error("witness on undistinguished pair");

endmodule

bind dfa_pair_distinguisher dpd_checker u_dpd_checker (.*);
